FILE: design/kntc_pkg.sv
// Shared constants, codes and controller/datapath link types for the dial gesture decoder.
package kntc_pkg;

   // Field and state widths
   localparam int KIND_W   = 2;
   localparam int DELTA_W  = 7;
   localparam int EVENT_W  = 3;
   localparam int SENS_W   = 8;
   localparam int DCT_W    = 16;
   localparam int OFFSET_W = 10;
   localparam int SUM_W    = OFFSET_W + 1;
   localparam int MS_W     = 17;
   localparam int COUNT_W  = 7;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK_TIME = 1'b1;

   localparam logic [SENS_W-1:0] SENS_RESET = 8'd8;
   localparam logic [DCT_W-1:0]  DCT_RESET  = 16'd300;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIAL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_LEFT    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_RIGHT   = 3'd1;
   localparam logic [EVENT_W-1:0] EV_PLEFT   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_PRIGHT  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_CLICK   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_DCLICK  = 3'd5;

   // Limits
   localparam logic [MS_W-1:0]     MS_MAX       = 17'h1FFFF;
   localparam logic [COUNT_W-1:0]  LAST_SLOT    = 7'd63;
   localparam logic [DELTA_W-1:0]  DELTA_MOST_NEG = 7'b1000000;
   localparam logic [DELTA_W-1:0]  DELTA_CLAMPED  = 7'b1000001;
   localparam logic signed [SUM_W-1:0] OFFSET_HI = 11'sd511;
   localparam logic signed [SUM_W-1:0] OFFSET_LO = -11'sd512;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture request fields
      logic apply;    // update gesture state, arm event generator
      logic advance;  // emit current event into the response register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ev_avail;   // generator has an event to send
      logic slot_free;  // response register can take an event
   } dp_status_type;

endpackage

FILE: design/kntc_req_if.sv
// Request channel: valid/ready handshake with the dial gesture input item.
interface kntc_req_if;
   logic                              valid;
   logic                              ready;
   logic [kntc_pkg::KIND_W-1:0]       kind;
   logic signed [kntc_pkg::DELTA_W-1:0] dial_delta;
   logic                              button_down;

   modport source (output valid, kind, dial_delta, button_down, input ready);
   modport sink   (input valid, kind, dial_delta, button_down, output ready);
endinterface

FILE: design/kntc_rsp_if.sv
// Response channel: valid/ready handshake carrying one gesture event.
interface kntc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kntc_pkg::EVENT_W-1:0] event_code;
   logic                         last_of_run;

   modport source (output valid, event_code, last_of_run, input ready);
   modport sink   (input valid, event_code, last_of_run, output ready);
endinterface

FILE: design/knob_turn_and_click_decoder_top.sv
// Top level of the push-button dial gesture decoder.
// Each request (a 1 ms tick, a dial rotation or a button change) is taken only
// while the decoder is idle and then passes through the apply and emit states;
// a dial request gives at most 64 events. The event generator emits one event
// per cycle into a response register; a stalled response holds the generator,
// and the final event of a request carries last_of_run. A request that produces
// no event (most ticks, presses, kind 3) goes from emit straight back to idle.
// A new request may be accepted while the last event of the previous one still
// waits in the response register.
// Configuration: csr_index 0 is sensitivity (0 acts as 1), csr_index 1 is
// double_click_time; write only while idle.
module knob_turn_and_click_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [kntc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kntc_pkg::CSR_DATA_W-1:0] csr_wdata,
   kntc_req_if.sink                        req_bus,
   kntc_rsp_if.source                      rsp_bus
);

   kntc_pkg::dp_cmd_type    cmd;
   kntc_pkg::dp_status_type status;

   // Sequencer
   kntc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // State and event generation
   kntc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_kind        (req_bus.kind),
      .req_dial_delta  (req_bus.dial_delta),
      .req_button_down (req_bus.button_down),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_event_code  (rsp_bus.event_code),
      .rsp_last_of_run (rsp_bus.last_of_run),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

FILE: design/kntc_datapath.sv
// Datapath: configuration, gesture state, event generator and response register.
module kntc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kntc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kntc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [kntc_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [kntc_pkg::DELTA_W-1:0] req_dial_delta,
   input  logic                                req_button_down,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [kntc_pkg::EVENT_W-1:0]        rsp_event_code,
   output logic                                rsp_last_of_run,
   input  kntc_pkg::dp_cmd_type                cmd,
   output kntc_pkg::dp_status_type             status
);

   // Configuration
   logic [kntc_pkg::SENS_W-1:0] sens_ff, sens_in;
   logic [kntc_pkg::DCT_W-1:0]  dct_ff, dct_in;

   // Captured request
   logic [kntc_pkg::KIND_W-1:0]         kind_ff, kind_in;
   logic signed [kntc_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic                                down_ff, down_in;

   // Gesture state
   logic                                 pushed_ff, pushed_in;
   logic                                 pending_ff, pending_in;
   logic                                 turned_ff, turned_in;
   logic signed [kntc_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [kntc_pkg::MS_W-1:0]            ms_ff, ms_in;

   // Event generator
   logic                           click_q_ff, click_q_in;
   logic                           dclick_q_ff, dclick_q_in;
   logic                           turn_on_ff, turn_on_in;
   logic                           dir_ff, dir_in;   // 1 right, 0 left
   logic [kntc_pkg::COUNT_W-1:0]   count_ff, count_in;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kntc_pkg::EVENT_W-1:0] rsp_code_ff, rsp_code_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Arithmetic
   logic [kntc_pkg::SENS_W-1:0]       sens_eff;
   logic signed [kntc_pkg::SUM_W-1:0] sens_ext, neg_sens, off_ext, sum, sum_sat, stepped;
   logic [kntc_pkg::MS_W-1:0]         ms_inc;
   logic cur_ok, nxt_ok, room, room_next, turn_avail, click_any, more;
   logic [kntc_pkg::EVENT_W-1:0] ev_code;

   // Step size, offset arithmetic and turn conditions
   always_comb begin
      sens_eff = (sens_ff == '0) ? kntc_pkg::SENS_W'(1) : sens_ff;
      sens_ext = $signed({{(kntc_pkg::SUM_W - kntc_pkg::SENS_W){1'b0}}, sens_eff});
      neg_sens = -sens_ext;
      off_ext  = kntc_pkg::SUM_W'(offset_ff);
      sum      = off_ext + kntc_pkg::SUM_W'(delta_ff);
      if (sum > kntc_pkg::OFFSET_HI) begin
         sum_sat = kntc_pkg::OFFSET_HI;
      end else if (sum < kntc_pkg::OFFSET_LO) begin
         sum_sat = kntc_pkg::OFFSET_LO;
      end else begin
         sum_sat = sum;
      end
      stepped   = dir_ff ? (off_ext - sens_ext) : (off_ext + sens_ext);
      cur_ok    = dir_ff ? (off_ext >= sens_ext) : (off_ext <= neg_sens);
      nxt_ok    = dir_ff ? (stepped >= sens_ext) : (stepped <= neg_sens);
      room      = (count_ff < kntc_pkg::COUNT_W'(64));
      room_next = room && (count_ff != kntc_pkg::LAST_SLOT);
      ms_inc    = (ms_ff == kntc_pkg::MS_MAX) ? ms_ff : ms_ff + 1'b1;
   end

   // Current event and whether another one follows it
   always_comb begin
      click_any  = click_q_ff || dclick_q_ff;
      turn_avail = turn_on_ff && cur_ok && room;
      more       = turn_on_ff && room_next && (click_any ? cur_ok : nxt_ok);
      if (dclick_q_ff) begin
         ev_code = kntc_pkg::EV_DCLICK;
      end else if (click_q_ff) begin
         ev_code = kntc_pkg::EV_CLICK;
      end else if (pushed_ff) begin
         ev_code = dir_ff ? kntc_pkg::EV_PRIGHT : kntc_pkg::EV_PLEFT;
      end else begin
         ev_code = dir_ff ? kntc_pkg::EV_RIGHT : kntc_pkg::EV_LEFT;
      end
   end

   assign status.ev_avail  = click_any || turn_avail;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   // Next-state logic
   always_comb begin
      sens_in     = sens_ff;
      dct_in      = dct_ff;
      kind_in     = kind_ff;
      delta_in    = delta_ff;
      down_in     = down_ff;
      pushed_in   = pushed_ff;
      pending_in  = pending_ff;
      turned_in   = turned_ff;
      offset_in   = offset_ff;
      ms_in       = ms_ff;
      click_q_in  = click_q_ff;
      dclick_q_in = dclick_q_ff;
      turn_on_in  = turn_on_ff;
      dir_in      = dir_ff;
      count_in    = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            kntc_pkg::CSR_SENSITIVITY:       sens_in = csr_wdata[kntc_pkg::SENS_W-1:0];
            kntc_pkg::CSR_DOUBLE_CLICK_TIME: dct_in  = csr_wdata[kntc_pkg::DCT_W-1:0];
            default: ;
         endcase
      end

      // capture request, most negative delta clamps to -63
      if (cmd.load) begin
         kind_in  = req_kind;
         delta_in = (req_dial_delta == kntc_pkg::DELTA_MOST_NEG)
                    ? kntc_pkg::DELTA_CLAMPED : req_dial_delta;
         down_in  = req_button_down;
      end

      // gesture state update and generator arming
      if (cmd.apply) begin
         count_in   = '0;
         turn_on_in = 1'b0;
         unique case (kind_ff)
            kntc_pkg::KIND_TICK: begin
               ms_in = ms_inc;
               if (pending_ff && !pushed_ff &&
                   (ms_inc > {{(kntc_pkg::MS_W - kntc_pkg::DCT_W){1'b0}}, dct_ff})) begin
                  click_q_in = 1'b1;
                  pending_in = 1'b0;
               end
            end
            kntc_pkg::KIND_DIAL: begin
               offset_in  = sum_sat[kntc_pkg::OFFSET_W-1:0];
               turned_in  = 1'b1;
               turn_on_in = (delta_ff != '0);
               dir_in     = !delta_ff[kntc_pkg::DELTA_W-1];
               if (!pushed_ff && pending_ff) begin
                  click_q_in = 1'b1;
                  pending_in = 1'b0;
               end
            end
            kntc_pkg::KIND_BUTTON: begin
               if (down_ff) begin
                  pushed_in = 1'b1;
                  turned_in = 1'b0;
                  offset_in = '0;
                  ms_in     = '0;
               end else begin
                  if (pending_ff) begin
                     dclick_q_in = 1'b1;
                     pending_in  = 1'b0;
                  end else if (!turned_ff) begin
                     pending_in = 1'b1;
                  end
                  pushed_in = 1'b0;
                  turned_in = 1'b0;
                  offset_in = '0;
               end
            end
            default: ;
         endcase
      end

      // response register: emit one event or drain
      if (cmd.advance) begin
         count_in     = count_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_code_in  = ev_code;
         rsp_last_in  = !more;
         if (click_any) begin
            click_q_in  = 1'b0;
            dclick_q_in = 1'b0;
         end else begin
            offset_in = stepped[kntc_pkg::OFFSET_W-1:0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff      <= kntc_pkg::SENS_RESET;
         dct_ff       <= kntc_pkg::DCT_RESET;
         pushed_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         turned_ff    <= 1'b0;
         offset_ff    <= '0;
         ms_ff        <= '0;
         click_q_ff   <= 1'b0;
         dclick_q_ff  <= 1'b0;
         turn_on_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sens_ff      <= sens_in;
         dct_ff       <= dct_in;
         pushed_ff    <= pushed_in;
         pending_ff   <= pending_in;
         turned_ff    <= turned_in;
         offset_ff    <= offset_in;
         ms_ff        <= ms_in;
         click_q_ff   <= click_q_in;
         dclick_q_ff  <= dclick_q_in;
         turn_on_ff   <= turn_on_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      delta_ff    <= delta_in;
      down_ff     <= down_in;
      dir_ff      <= dir_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_code  = rsp_code_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // An event marked last leaves the generator empty
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && !more |=> !status.ev_avail)
      else $error("event marked last but generator still has events");

   // An event not marked last is followed by another
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && more |=> status.ev_avail)
      else $error("event not marked last but generator is empty");

   // Per-request event cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kntc_pkg::COUNT_W'(64))
      else $error("event count beyond cap");

   // Emitting never overwrites an untaken response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");
`endif

endmodule

FILE: design/kntc_ctrl.sv
// Controller: sequences request capture, state update and per-event emission.
module kntc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kntc_pkg::dp_status_type status,
   output kntc_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_APPLY = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Handshake and commands
   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.load    = req_valid && req_ready;
   assign cmd.apply   = (state_ff == ST_APPLY);
   assign cmd.advance = (state_ff == ST_EMIT) && status.ev_avail && status.slot_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cmd.load) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_EMIT;
         ST_EMIT:  if (!status.ev_avail) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sim/knob_turn_and_click_decoder_top_tb.sv
// Self-checking testbench for the dial gesture decoder: directed table, random gestures, scoreboard.
`timescale 1ns / 1ps

module knob_turn_and_click_decoder_top_tb;
   import kntc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int USE_MODEL    = -1;   // row expectation comes from the predictor
   localparam int MAX_EVENTS   = int'(LAST_SLOT) + 1;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 8;
   localparam int END_CYCLES   = 80;
   localparam int HOLD_CYCLES  = 500;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 105;

   typedef struct packed {
      logic [EVENT_W-1:0] code;
      logic               last;
   } gesture_event_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DELTA_W-1:0] raw_delta;
      logic               down;
      int                 typed_n;
      logic [EVENT_W-1:0] typed_code;
   } stim_row_type;

   // Directed table, reset settings: sensitivity 8, double-click time 300
   localparam stim_row_type DIR_TABLE [22] = '{
      '{KIND_TICK,      7'd0,           1'b0, 0,         EV_LEFT},
      '{KIND_UNUSED,    7'd63,          1'b1, 0,         EV_LEFT},   // ignored kind
      '{KIND_DIAL,      7'd8,           1'b0, 1,         EV_RIGHT},
      '{KIND_DIAL,      -7'sd8,         1'b0, 1,         EV_LEFT},
      '{KIND_DIAL,      DELTA_MOST_NEG, 1'b0, 7,         EV_LEFT},   // clamps to -63
      '{KIND_DIAL,      7'd63,          1'b0, 7,         EV_RIGHT},
      '{KIND_BUTTON,    7'd0,           1'b1, 0,         EV_LEFT},
      '{KIND_DIAL,      7'd16,          1'b0, 2,         EV_PRIGHT},
      '{KIND_DIAL,      -7'sd8,         1'b1, 1,         EV_PLEFT},
      '{KIND_BUTTON,    7'd0,           1'b0, 0,         EV_LEFT},   // turned: no click
      '{KIND_BUTTON,    7'd0,           1'b1, 0,         EV_LEFT},
      '{KIND_BUTTON,    7'd0,           1'b0, 0,         EV_LEFT},   // arms click
      '{KIND_BUTTON,    7'd0,           1'b1, 0,         EV_LEFT},
      '{KIND_BUTTON,    7'd0,           1'b0, 1,         EV_DCLICK},
      '{KIND_BUTTON,    7'd0,           1'b1, 0,         EV_LEFT},
      '{KIND_BUTTON,    7'd0,           1'b0, 0,         EV_LEFT},
      '{KIND_DIAL,      7'd0,           1'b0, 1,         EV_CLICK},  // zero delta flushes click
      '{KIND_BUTTON,    7'd0,           1'b1, 0,         EV_LEFT},
      '{KIND_BUTTON,    7'd0,           1'b0, 0,         EV_LEFT},
      '{KIND_DIAL,      7'd8,           1'b0, USE_MODEL, EV_LEFT},   // click, then turn
      '{KIND_BUTTON,    7'd0,           1'b0, USE_MODEL, EV_LEFT},   // release without press
      '{KIND_BUTTON,    7'd0,           1'b0, USE_MODEL, EV_LEFT}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kntc_req_if req_bus ();
   kntc_rsp_if rsp_bus ();

   knob_turn_and_click_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #1 clock = ~clock;

   // Predictor state and settings
   logic                        is_pushed;
   logic                        click_pending;
   logic                        turned_while_pushed;
   logic signed [OFFSET_W-1:0]  dial_offset;
   logic [MS_W-1:0]             ms_since_press;
   logic [SENS_W-1:0]           sensitivity;
   logic [DCT_W-1:0]            double_click_time;

   gesture_event_type expected_events [$];
   gesture_event_type step_events [$];

   int error_count    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int tick_span      = 4;
   bit hold_request   = 1'b0;

   task automatic report_mismatch(input string what);
      $display("[%0t] ERROR %s", $realtime, what);
      error_count++;
   endtask

   function automatic void push_event(input logic [EVENT_W-1:0] code);
      if (step_events.size() < MAX_EVENTS)
         step_events.push_back('{code: code, last: 1'b0});
   endfunction

   // Gesture decode of one request into step_events
   function automatic void decode_gesture(input logic [KIND_W-1:0] kind,
                                          input logic [DELTA_W-1:0] raw,
                                          input logic down);
      int delta;
      int sens;
      int ofs;
      step_events.delete();
      case (kind)
         KIND_TICK: begin
            if (ms_since_press < MS_MAX)
               ms_since_press++;
            if (click_pending && !is_pushed && ms_since_press > double_click_time) begin
               push_event(EV_CLICK);
               click_pending = 1'b0;
            end
         end
         KIND_DIAL: begin
            delta = $signed(raw);
            if (delta < -63)
               delta = -63;
            sens = (sensitivity == 0) ? 1 : int'(sensitivity);
            turned_while_pushed = 1'b1;
            ofs = dial_offset + delta;
            if (ofs > 511)
               ofs = 511;
            if (ofs < -512)
               ofs = -512;
            if (!is_pushed && click_pending) begin
               push_event(EV_CLICK);
               click_pending = 1'b0;
            end
            if (delta < 0) begin
               while (ofs <= -sens && step_events.size() < MAX_EVENTS) begin
                  push_event(is_pushed ? EV_PLEFT : EV_LEFT);
                  ofs += sens;
               end
            end else if (delta > 0) begin
               while (ofs >= sens && step_events.size() < MAX_EVENTS) begin
                  push_event(is_pushed ? EV_PRIGHT : EV_RIGHT);
                  ofs -= sens;
               end
            end
            dial_offset = OFFSET_W'(ofs);
         end
         KIND_BUTTON: begin
            if (down) begin
               is_pushed = 1'b1;
               ms_since_press = '0;
            end else begin
               if (click_pending) begin
                  push_event(EV_DCLICK);
                  click_pending = 1'b0;
               end else if (!turned_while_pushed) begin
                  click_pending = 1'b1;
               end
               is_pushed = 1'b0;
            end
            turned_while_pushed = 1'b0;
            dial_offset = '0;
         end
         default: ;
      endcase
      if (step_events.size() > 0)
         step_events[step_events.size()-1].last = 1'b1;
   endfunction

   // Offer one request, hold it until taken, then queue its expected events
   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [DELTA_W-1:0] raw,
                           input logic down, input int typed_n = USE_MODEL,
                           input logic [EVENT_W-1:0] typed_code = EV_LEFT);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.dial_delta  <= raw;
      req_bus.button_down <= down;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      decode_gesture(kind, raw, down);
      if (typed_n == USE_MODEL) begin
         foreach (step_events[i])
            expected_events.push_back(step_events[i]);
      end else begin
         for (int i = 0; i < typed_n; i++)
            expected_events.push_back('{code: typed_code, last: (i == typed_n - 1)});
      end
      if (kind != KIND_UNUSED)
         items_sent++;
   endtask

   // Let every expected event drain and the block go idle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers; sensitivity gets junk in its unused upper bits
   task automatic configure(input logic [SENS_W-1:0] sens, input logic [DCT_W-1:0] dct);
      logic [CSR_DATA_W-SENS_W-1:0] junk;
      junk = (CSR_DATA_W-SENS_W)'($urandom_range(0, 255));
      csr_we    <= 1'b1;
      csr_index <= CSR_SENSITIVITY;
      csr_wdata <= {junk, sens};
      @(posedge clock);
      csr_index <= CSR_DOUBLE_CLICK_TIME;
      csr_wdata <= dct;
      @(posedge clock);
      csr_we <= 1'b0;
      sensitivity       = sens;
      double_click_time = dct;
      tick_span         = (dct > 22) ? 24 : int'(dct) + 2;
   endtask

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 3))
         0, 1:    return DELTA_W'($urandom_range(0, 127));
         2:       return DELTA_W'($urandom_range(0, 3));
         default: return DELTA_W'(-$urandom_range(1, 3));
      endcase
   endfunction

   task automatic tick_burst();
      int n;
      n = $urandom_range(0, tick_span);
      repeat (n) send_req(KIND_TICK, pick_delta(), 1'($urandom_range(0, 1)));
   endtask

   // One random gesture: mostly well formed, some noise
   task automatic random_gesture();
      int n;
      case ($urandom_range(0, 9))
         0, 1: begin  // single click
            send_req(KIND_BUTTON, pick_delta(), 1'b1);
            send_req(KIND_BUTTON, pick_delta(), 1'b0);
            tick_burst();
         end
         2: begin  // double click
            send_req(KIND_BUTTON, pick_delta(), 1'b1);
            send_req(KIND_BUTTON, pick_delta(), 1'b0);
            repeat ($urandom_range(0, 2)) send_req(KIND_TICK, pick_delta(), 1'b0);
            send_req(KIND_BUTTON, pick_delta(), 1'b1);
            send_req(KIND_BUTTON, pick_delta(), 1'b0);
         end
         3, 4: begin  // turn while pushed, ticks while held
            send_req(KIND_BUTTON, pick_delta(), 1'b1);
            n = $urandom_range(1, 4);
            repeat (n) send_req(KIND_DIAL, pick_delta(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
               tick_burst();
            send_req(KIND_BUTTON, pick_delta(), 1'b0);
         end
         5, 6: begin  // plain turns
            n = $urandom_range(1, 4);
            repeat (n) send_req(KIND_DIAL, pick_delta(), 1'($urandom_range(0, 1)));
         end
         7: tick_burst();
         default: begin  // noise
            n = $urandom_range(1, 3);
            repeat (n) send_req(KIND_W'($urandom_range(0, 3)), pick_delta(),
                                1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic [SENS_W-1:0] sens, input logic [DCT_W-1:0] dct,
                            input bit squeeze);
      int goal;
      wait_idle();
      configure(sens, dct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      goal = items_sent + PHASE_ITEMS;
      if (squeeze)
         hold_request = 1'b1;
      while (items_sent < goal)
         random_gesture();
   endtask

   // Response side: random stalls plus one long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Scoreboard: each accepted event against the oldest expectation
   always @(posedge clock) begin : event_check
      gesture_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event code %0d last %0b",
                                      rsp_bus.event_code, rsp_bus.last_of_run));
         end else begin
            want = expected_events.pop_front();
            if (rsp_bus.event_code !== want.code || rsp_bus.last_of_run !== want.last)
               report_mismatch($sformatf("event code %0d last %0b, expected %0d last %0b",
                                         rsp_bus.event_code, rsp_bus.last_of_run,
                                         want.code, want.last));
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("knob_turn_and_click_decoder_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_SENSITIVITY;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_TICK;
      req_bus.dial_delta  <= '0;
      req_bus.button_down <= 1'b0;
      is_pushed           = 1'b0;
      click_pending       = 1'b0;
      turned_while_pushed = 1'b0;
      dial_offset         = '0;
      ms_since_press      = '0;
      sensitivity         = SENS_RESET;
      double_click_time   = DCT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset settings
      foreach (DIR_TABLE[i])
         send_req(DIR_TABLE[i].kind, DIR_TABLE[i].raw_delta, DIR_TABLE[i].down,
                  DIR_TABLE[i].typed_n, DIR_TABLE[i].typed_code);

      // Build a large offset at coarse sensitivity, then hit the event cap at 1
      wait_idle();
      configure(8'd255, DCT_RESET);
      send_req(KIND_BUTTON, 7'd0, 1'b1);
      repeat (4) send_req(KIND_DIAL, 7'd63, 1'b0);
      wait_idle();
      configure(8'd1, DCT_RESET);
      send_req(KIND_DIAL, 7'd1, 1'b0);
      send_req(KIND_DIAL, -7'sd1, 1'b0);
      send_req(KIND_DIAL, 7'd1, 1'b0);
      send_req(KIND_BUTTON, 7'd0, 1'b0);

      // Random phases: idling mix and settings, extremes included
      run_phase(0, 0, 8'd1, 16'd0, 1'b1);
      run_phase(62, 0, 8'd255, 16'hFFFF, 1'b0);
      run_phase(0, 62, 8'd0, 16'd5, 1'b0);
      run_phase(34, 34, SENS_W'($urandom_range(2, 16)), DCT_W'($urandom_range(0, 20)), 1'b0);

      // Drain and finish
      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_events.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
      if (error_count == 0)
         $display("knob_turn_and_click_decoder_top: match");
      else
         $display("knob_turn_and_click_decoder_top: mismatch");
      $finish;
   end

endmodule
